>>> hw/rtl/point_cloud_height_band_crop_top_defines.svh
// Assertion macros for the crop filter RTL, used by pchbc_band.
`ifndef POINT_CLOUD_HEIGHT_BAND_CROP_TOP_DEFINES_SVH
`define POINT_CLOUD_HEIGHT_BAND_CROP_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define PCHBC_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("pchbc assertion failed");
`define PCHBC_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("pchbc forbidden condition");
`else
`define PCHBC_ASSERT(lbl, clk, rst, prop)
`define PCHBC_NEVER(lbl, clk, rst, cond)
`endif
`endif

>>> hw/rtl/pchbc_pkg.sv
`timescale 1ns / 1ps
package pchbc_pkg;

  localparam int VOXEL_HALF_WIDTH = 10;
  localparam int VOXEL_MM = 1000;
  localparam int Q_FRAC_BITS = 12;

  localparam int COORD_W = 24;
  localparam int DIFF_W = 25;
  localparam int RAD_W = 52;
  localparam int ROOT_W = 26;
  localparam int REM_W = 29;
  localparam int SQRT_STAGES = ROOT_W / 2;
  localparam int MARGIN_W = 42;
  localparam int CMP_W = 45;

  localparam logic [23:0] MAX_RANGE_RST = 24'(VOXEL_MM * (VOXEL_HALF_WIDTH + 1));

  typedef enum logic [7:0] {
    REG_VEH_X     = 8'd0,
    REG_VEH_Y     = 8'd1,
    REG_VEH_Z     = 8'd2,
    REG_MIN_H     = 8'd3,
    REG_MAX_H     = 8'd4,
    REG_SLOPE     = 8'd5,
    REG_MAX_RANGE = 8'd6,
    REG_SCAN_AGE  = 8'd7
  } reg_idx_t;

  // Point data that rides along the pipeline.
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic signed [DIFF_W-1:0]  rz;
  } item_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_acc_t;

  // One digit of the restoring square root: brings in two radicand bits.
  function automatic sqrt_acc_t sqrt_step(sqrt_acc_t acc, logic [1:0] bits);
    logic [REM_W-1:0] r2;
    logic [REM_W-1:0] trial;
    sqrt_acc_t res;
    r2 = {acc.rem[REM_W-3:0], bits};
    trial = {1'b0, acc.root, 2'b01};
    if (r2 >= trial) begin
      res.rem = r2 - trial;
      res.root = {acc.root[ROOT_W-2:0], 1'b1};
    end else begin
      res.rem = r2;
      res.root = {acc.root[ROOT_W-2:0], 1'b0};
    end
    return res;
  endfunction

endpackage

>>> hw/rtl/pchbc_front.sv
`timescale 1ns / 1ps
// Offsets from the vehicle, their squares, then the sum of squares.
module pchbc_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  logic signed [pchbc_pkg::COORD_W-1:0] px,
  input  logic signed [pchbc_pkg::COORD_W-1:0] py,
  input  logic signed [pchbc_pkg::COORD_W-1:0] pz,
  input  logic signed [pchbc_pkg::COORD_W-1:0] vx,
  input  logic signed [pchbc_pkg::COORD_W-1:0] vy,
  input  logic signed [pchbc_pkg::COORD_W-1:0] vz,
  output logic                                 valid,
  output logic [pchbc_pkg::RAD_W-1:0]          radicand,
  output pchbc_pkg::item_t                     item
);

  logic signed [pchbc_pkg::DIFF_W-1:0] dx, dy;
  logic [pchbc_pkg::COORD_W-1:0] adx, ady;
  logic [2*pchbc_pkg::COORD_W-1:0] sqx, sqy;
  logic v1, v2;
  pchbc_pkg::item_t it1, it2;
  pchbc_pkg::item_t it0;

  always_comb begin
    it0.x = px;
    it0.y = py;
    it0.z = pz;
    it0.rz = pchbc_pkg::DIFF_W'(pz) - pchbc_pkg::DIFF_W'(vz);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      valid <= v2;
    end
    if (en) begin
      dx <= pchbc_pkg::DIFF_W'(px) - pchbc_pkg::DIFF_W'(vx);
      dy <= pchbc_pkg::DIFF_W'(py) - pchbc_pkg::DIFF_W'(vy);
      it1 <= it0;
      sqx <= adx * adx;
      sqy <= ady * ady;
      it2 <= it1;
      radicand <= pchbc_pkg::RAD_W'(sqx) + pchbc_pkg::RAD_W'(sqy);
      item <= it2;
    end
  end

  // Magnitudes stay below 2^24, so 24 bits hold them.
  assign adx = dx[pchbc_pkg::DIFF_W-1] ? pchbc_pkg::COORD_W'(-dx) : dx[pchbc_pkg::COORD_W-1:0];
  assign ady = dy[pchbc_pkg::DIFF_W-1] ? pchbc_pkg::COORD_W'(-dy) : dy[pchbc_pkg::COORD_W-1:0];

endmodule

>>> hw/rtl/pchbc_isqrt.sv
`timescale 1ns / 1ps
// Pipelined integer square root, two result bits per stage.
module pchbc_isqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [pchbc_pkg::RAD_W-1:0]   radicand,
  input  pchbc_pkg::item_t              in_item,
  output logic                          valid,
  output logic [pchbc_pkg::ROOT_W-1:0]  root,
  output pchbc_pkg::item_t              item
);

  localparam int NS = pchbc_pkg::SQRT_STAGES;

  logic [NS-1:0] v;
  logic [pchbc_pkg::RAD_W-1:0] rad [NS];
  pchbc_pkg::sqrt_acc_t acc [NS];
  pchbc_pkg::item_t it [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic vin;
    logic [pchbc_pkg::RAD_W-1:0] rin;
    pchbc_pkg::sqrt_acc_t ain, amid, anext;
    pchbc_pkg::item_t iin;

    if (s == 0) begin : g_first
      assign vin = in_valid;
      assign rin = radicand;
      assign ain = '0;
      assign iin = in_item;
    end else begin : g_rest
      assign vin = v[s-1];
      assign rin = rad[s-1];
      assign ain = acc[s-1];
      assign iin = it[s-1];
    end

    always_comb begin
      amid = pchbc_pkg::sqrt_step(ain, rin[pchbc_pkg::RAD_W-1 -: 2]);
      anext = pchbc_pkg::sqrt_step(amid, rin[pchbc_pkg::RAD_W-3 -: 2]);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[s] <= 1'b0;
      end else if (en) begin
        v[s] <= vin;
      end
      if (en) begin
        rad[s] <= {rin[pchbc_pkg::RAD_W-5:0], 4'b0000};
        acc[s] <= anext;
        it[s] <= iin;
      end
    end
  end

  assign valid = v[NS-1];
  assign root = acc[NS-1].root;
  assign item = it[NS-1];

endmodule

>>> hw/rtl/pchbc_band.sv
`timescale 1ns / 1ps
`include "point_cloud_height_band_crop_top_defines.svh"
// Range test, slope margin, height band test and the output register.
module pchbc_band (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  logic [pchbc_pkg::ROOT_W-1:0]         radius,
  input  pchbc_pkg::item_t                     in_item,
  input  logic signed [pchbc_pkg::COORD_W-1:0] min_height,
  input  logic signed [pchbc_pkg::COORD_W-1:0] max_height,
  input  logic [15:0]                          slope_ratio,
  input  logic [pchbc_pkg::COORD_W-1:0]        range_limit,
  input  logic [31:0]                          scan_age,
  output logic                                 out_valid,
  output logic signed [pchbc_pkg::COORD_W-1:0] kept_x,
  output logic signed [pchbc_pkg::COORD_W-1:0] kept_y,
  output logic signed [pchbc_pkg::COORD_W-1:0] kept_z,
  output logic [31:0]                          time_stamp
);

  localparam int CW = pchbc_pkg::CMP_W;

  logic va, vb, range_ok;
  logic [pchbc_pkg::ROOT_W-1:0] da;
  logic [pchbc_pkg::MARGIN_W-1:0] margin;
  pchbc_pkg::item_t ita, itb;
  logic signed [CW-1:0] rz_q, lo_q, hi_q;
  logic pass_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      va <= in_valid;
      vb <= va;
      out_valid <= vb && pass_b;
    end
    if (en) begin
      da <= radius;
      ita <= in_item;
      range_ok <= da < pchbc_pkg::ROOT_W'(range_limit);
      margin <= pchbc_pkg::MARGIN_W'(slope_ratio) * pchbc_pkg::MARGIN_W'(da);
      itb <= ita;
      kept_x <= itb.x;
      kept_y <= itb.y;
      kept_z <= itb.z;
      time_stamp <= scan_age;
    end
  end

  always_comb begin
    rz_q = CW'(itb.rz) <<< pchbc_pkg::Q_FRAC_BITS;
    lo_q = (CW'(min_height) <<< pchbc_pkg::Q_FRAC_BITS) - CW'(margin);
    hi_q = (CW'(max_height) <<< pchbc_pkg::Q_FRAC_BITS) + CW'(margin);
    pass_b = range_ok && (rz_q > lo_q) && (rz_q < hi_q);
  end

  `PCHBC_ASSERT(a_drop, clk, rst, en && vb && !pass_b |=> !out_valid)
  `PCHBC_ASSERT(a_keep, clk, rst, en && vb && pass_b |=> out_valid)
  `PCHBC_ASSERT(a_hold, clk, rst, !en |=> $stable(out_valid) && $stable(kept_x))
  `PCHBC_NEVER(a_far, clk, rst, out_valid && $past(en) && $past(!range_ok))

endmodule

>>> hw/rtl/point_cloud_height_band_crop_top.sv
`timescale 1ns / 1ps
// Lidar point range and height band crop filter.
// Input channel: one point request per accepted cycle (in_valid high, in_stall
// low) carrying point_x, point_y and point_z in signed millimetres.
// Output channel: a request on out_valid with kept_x/y/z and time_stamp is
// produced only for points inside the range and height band; others vanish.
// Throughput is one point per clock while in_stall is low. The pipeline has
// 19 register stages: three front stages (offsets, squares, sum), thirteen
// square root stages resolving two root bits each, two band stages and the
// output register. The first stage loads at the edge that accepts a point.
// The whole pipeline advances together; when the output register holds a
// request that the receiver stalls, in_stall rises and every stage freezes,
// so nothing is lost or repeated. Empty stages do not free up a stall.
// Reset (rst, synchronous) clears all valid bits and loads the register
// defaults: vehicle at the origin, band -1500..200 mm, slope 819 (Q4.12),
// range 11000 mm, scan age 0. Configuration writes are taken every cycle and
// should only be made while the pipeline is empty.
module point_cloud_height_band_crop_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [23:0] point_x,
  input  logic signed [23:0] point_y,
  input  logic signed [23:0] point_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [23:0] kept_x,
  output logic signed [23:0] kept_y,
  output logic signed [23:0] kept_z,
  output logic [31:0]        time_stamp
);

  logic signed [23:0] veh_x, veh_y, veh_z, min_height, max_height;
  logic [15:0] slope_ratio;
  logic [23:0] range_limit;
  logic [31:0] scan_age;

  logic en;
  logic f_valid, s_valid;
  logic [pchbc_pkg::RAD_W-1:0] radicand;
  logic [pchbc_pkg::ROOT_W-1:0] radius;
  pchbc_pkg::item_t f_item, s_item;

  // Register file; unknown indexes are ignored, upper data bits dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      veh_x <= '0;
      veh_y <= '0;
      veh_z <= '0;
      min_height <= -24'sd1500;
      max_height <= 24'sd200;
      slope_ratio <= 16'd819;
      range_limit <= pchbc_pkg::MAX_RANGE_RST;
      scan_age <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        pchbc_pkg::REG_VEH_X:     veh_x <= cfg_data[23:0];
        pchbc_pkg::REG_VEH_Y:     veh_y <= cfg_data[23:0];
        pchbc_pkg::REG_VEH_Z:     veh_z <= cfg_data[23:0];
        pchbc_pkg::REG_MIN_H:     min_height <= cfg_data[23:0];
        pchbc_pkg::REG_MAX_H:     max_height <= cfg_data[23:0];
        pchbc_pkg::REG_SLOPE:     slope_ratio <= cfg_data[15:0];
        pchbc_pkg::REG_MAX_RANGE: range_limit <= cfg_data[23:0];
        pchbc_pkg::REG_SCAN_AGE:  scan_age <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // The pipeline moves whenever the output slot is free or being taken.
  assign en = !out_valid || !out_stall;
  assign in_stall = !en;

  pchbc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (in_valid),
    .px       (point_x),
    .py       (point_y),
    .pz       (point_z),
    .vx       (veh_x),
    .vy       (veh_y),
    .vz       (veh_z),
    .valid    (f_valid),
    .radicand (radicand),
    .item     (f_item)
  );

  pchbc_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (f_valid),
    .radicand (radicand),
    .in_item  (f_item),
    .valid    (s_valid),
    .root     (radius),
    .item     (s_item)
  );

  pchbc_band u_band (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .in_valid    (s_valid),
    .radius      (radius),
    .in_item     (s_item),
    .min_height  (min_height),
    .max_height  (max_height),
    .slope_ratio (slope_ratio),
    .range_limit (range_limit),
    .scan_age    (scan_age),
    .out_valid   (out_valid),
    .kept_x      (kept_x),
    .kept_y      (kept_y),
    .kept_z      (kept_z),
    .time_stamp  (time_stamp)
  );

endmodule
